// ----- hw/rtl/stereo_channel_mixer_core_assert.svh -----
// Assertion macros shared by the stereo channel mixer RTL.
`ifndef STEREO_CHANNEL_MIXER_CORE_ASSERT_SVH
`define STEREO_CHANNEL_MIXER_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define SCM_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define SCM_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/scm_pkg.sv -----
// Package: types, constants and the channel gain function of the stereo channel mixer.
`default_nettype none

package scm_pkg;

	localparam int ACC_WIDTH_DEF = 32;
	localparam int CONTRIB_W     = 19;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
	localparam int PADDR_W       = 4;
	localparam int PDATA_W       = 32;

	// Register indexes (byte address / 4)
	localparam logic [1:0] REG_MASTER_VOLUME = 2'd0;
	localparam logic [1:0] REG_OUTPUT_8BIT   = 2'd1;
	localparam logic [1:0] REG_OUTPUT_STEREO = 2'd2;

	localparam logic [9:0] MASTER_VOLUME_RST = 10'd256;
	localparam logic       OUTPUT_8BIT_RST   = 1'b0;
	localparam logic       OUTPUT_STEREO_RST = 1'b1;

	localparam logic signed [15:0] SAT_MAX = 16'sh7fff;
	localparam logic signed [15:0] SAT_MIN = 16'sh8000;

	typedef logic signed [CONTRIB_W-1:0] contrib_t;

	typedef struct packed {
		logic signed [15:0] sample_value;
		logic               sample_is_8bit;
		logic [9:0]         left_volume;
		logic [9:0]         right_volume;
		logic               last_channel;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
	} out_word_t;

	typedef struct packed {
		contrib_t left_contrib;
		contrib_t right_contrib;
		logic     last_channel;
	} queue_word_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef struct packed {
		logic [9:0] master_volume;
		logic       output_8bit;
		logic       output_stereo;
	} cfg_t;

	// One channel's contribution to one side: 16-bit source gives (s*vol)>>8,
	// 8-bit source gives byte*(min(vol,255)>>3)*8. One shared multiplier.
	function automatic contrib_t contribution(logic signed [15:0] sample, logic is8,
			logic [9:0] vol);
		logic signed [15:0] a;
		logic [9:0]         b;
		logic signed [26:0] p;
		a = is8 ? {{8{sample[7]}}, sample[7:0]} : sample;
		b = is8 ? ((vol[9:8] != 2'b00) ? 10'd31 : {5'd0, vol[7:3]}) : vol;
		p = 27'(a) * 27'($signed({1'b0, b}));
		return is8 ? contrib_t'({p[15:0], 3'b000}) : contrib_t'(p[26:8]);
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/scm_front.sv -----
// Front end: accept a channel word, compute both side contributions, push to the queue.
`default_nettype none

module scm_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  sample_valid,
	output logic                 sample_ready,
	input  scm_pkg::in_word_t    sample_word,
	input  scm_pkg::queue_stat_t qstat,
	output logic                 push,
	output scm_pkg::queue_word_t push_word
);
	import scm_pkg::*;

	logic        valid_s1;
	queue_word_t word_s1;

	assign push         = valid_s1 && !qstat.full;
	assign sample_ready = !valid_s1 || !qstat.full;
	assign push_word    = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			word_s1.left_contrib  <= contribution(sample_word.sample_value,
				sample_word.sample_is_8bit, sample_word.left_volume);
			word_s1.right_contrib <= contribution(sample_word.sample_value,
				sample_word.sample_is_8bit, sample_word.right_volume);
			word_s1.last_channel  <= sample_word.last_channel;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/scm_queue.sv -----
// Short FIFO between the front end and the back end.
`default_nettype none

module scm_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  scm_pkg::queue_word_t push_word,
	input  wire                  pop,
	output scm_pkg::queue_word_t pop_word,
	output scm_pkg::queue_stat_t qstat
);
	import scm_pkg::*;

	queue_word_t         entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign qstat.full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign pop_word    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/scm_back.sv -----
// Back end: accumulate contributions, scale and saturate the frame, hold the result word.
`default_nettype none

module scm_back #(
	parameter int ACC_WIDTH = scm_pkg::ACC_WIDTH_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  scm_pkg::cfg_t        cfg,
	input  scm_pkg::queue_stat_t qstat,
	input  scm_pkg::queue_word_t pop_word,
	output logic                 pop,
	output logic                 finishing,
	output logic                 frame_valid,
	input  wire                  frame_ready,
	output scm_pkg::out_word_t   frame_word
);
	import scm_pkg::*;

	localparam int PROD_W = ACC_WIDTH + 11;
	localparam int VAL_W  = PROD_W - 8;

	localparam logic [1:0] ST_ACC = 2'd0;
	localparam logic [1:0] ST_MUL = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	logic [1:0]                  state_q;
	logic signed [ACC_WIDTH-1:0] acc_l_q, acc_r_q;
	logic signed [ACC_WIDTH-1:0] fin_l_q, fin_r_q;
	logic signed [PROD_W-1:0]    prod_l_q, prod_r_q;
	logic signed [ACC_WIDTH-1:0] sum_l, sum_r;
	logic                        out_valid_q;
	out_word_t                   out_word_q;
	logic signed [15:0]          res_l, res_r;
	logic                        load_out;

	function automatic logic signed [15:0] finish(logic signed [PROD_W-1:0] prod,
			logic out8);
		logic signed [VAL_W-1:0] v;
		logic signed [15:0]      s;
		v = prod[PROD_W-1:8];
		if (!v[VAL_W-1] && (|v[VAL_W-2:15])) begin
			s = SAT_MAX;
		end else if (v[VAL_W-1] && !(&v[VAL_W-2:15])) begin
			s = SAT_MIN;
		end else begin
			s = v[15:0];
		end
		return out8 ? $signed({8'd0, ~s[15], s[14:8]}) : s;
	endfunction

	assign pop       = (state_q == ST_ACC) && !qstat.empty;
	assign finishing = (state_q == ST_SAT);
	assign load_out  = finishing && (!out_valid_q || frame_ready);
	assign sum_l     = acc_l_q + ACC_WIDTH'(pop_word.left_contrib);
	assign sum_r     = acc_r_q + ACC_WIDTH'(pop_word.right_contrib);
	assign res_l     = finish(prod_l_q, cfg.output_8bit);
	assign res_r     = cfg.output_stereo ? finish(prod_r_q, cfg.output_8bit) : 16'sd0;

	assign frame_valid = out_valid_q;
	assign frame_word  = out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			acc_l_q     <= '0;
			acc_r_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (frame_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_ACC: begin
					if (pop) begin
						if (pop_word.last_channel) begin
							acc_l_q <= '0;
							acc_r_q <= '0;
							state_q <= ST_MUL;
						end else begin
							acc_l_q <= sum_l;
							acc_r_q <= sum_r;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					if (load_out) begin
						state_q <= ST_ACC;
					end
				end
				default: begin
					state_q <= ST_ACC;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && pop_word.last_channel) begin
			fin_l_q <= sum_l;
			fin_r_q <= sum_r;
		end
		if (state_q == ST_MUL) begin
			prod_l_q <= PROD_W'(fin_l_q) * PROD_W'($signed({1'b0, cfg.master_volume}));
			prod_r_q <= PROD_W'(fin_r_q) * PROD_W'($signed({1'b0, cfg.master_volume}));
		end
		if (load_out) begin
			out_word_q.left_sample  <= res_l;
			out_word_q.right_sample <= res_r;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/stereo_channel_mixer_core.sv -----
// Top level of the stereo channel mixer: register port, front end, queue, back end.
//
//  channel   handshake                    word / data
//  -------   --------------------------   ----------------------------------
//  sample    sample_valid / sample_ready   sample_word (scm_pkg::in_word_t)
//  frame     frame_valid / frame_ready     frame_word  (scm_pkg::out_word_t)
//  config    psel, penable, pwrite, pready paddr[3:0], pwdata / prdata, 32 bit
//
//  The front end takes one sample word per cycle while the queue has room and
//  registers both side gains through one 16x11 multiplier per side. The back end
//  drains the queue at one word per cycle while accumulating; a word marked last
//  passes the add, master-volume multiply and saturate steps plus any wait on
//  frame_ready. Words reach the accumulators via the front-end register and queue.
//  Reset clears accumulators, queue and handshakes and loads the register defaults.
//  A stalled frame port holds the result word; the four-entry queue then fills and
//  sample_ready drops.
`default_nettype none
`include "stereo_channel_mixer_core_assert.svh"

module stereo_channel_mixer_core #(
	parameter int ACC_WIDTH = scm_pkg::ACC_WIDTH_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          sample_valid,
	output logic                         sample_ready,
	input  scm_pkg::in_word_t            sample_word,
	output logic                         frame_valid,
	input  wire                          frame_ready,
	output scm_pkg::out_word_t           frame_word,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [scm_pkg::PADDR_W-1:0]   paddr,
	input  wire [scm_pkg::PDATA_W-1:0]   pwdata,
	output logic [scm_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import scm_pkg::*;

	cfg_t        cfg_q;
	queue_stat_t qstat;
	queue_word_t push_word;
	queue_word_t pop_word;
	logic        push;
	logic        pop;
	logic        finishing;
	logic        cfg_write;
	logic [1:0]  reg_index;

	// Register port: zero wait states, write in the access phase.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_index = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.master_volume <= MASTER_VOLUME_RST;
			cfg_q.output_8bit   <= OUTPUT_8BIT_RST;
			cfg_q.output_stereo <= OUTPUT_STEREO_RST;
		end else if (cfg_write) begin
			unique case (reg_index)
				REG_MASTER_VOLUME: cfg_q.master_volume <= pwdata[9:0];
				REG_OUTPUT_8BIT:   cfg_q.output_8bit   <= pwdata[0];
				REG_OUTPUT_STEREO: cfg_q.output_stereo <= pwdata[0];
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	// Read back: zero-extend the addressed register, zero for unused addresses.
	always_comb begin
		unique case (reg_index)
			REG_MASTER_VOLUME: prdata = PDATA_W'(cfg_q.master_volume);
			REG_OUTPUT_8BIT:   prdata = PDATA_W'(cfg_q.output_8bit);
			REG_OUTPUT_STEREO: prdata = PDATA_W'(cfg_q.output_stereo);
			default:           prdata = '0;
		endcase
	end

	// Front end: accept and compute per-side contributions.
	scm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample_word  (sample_word),
		.qstat        (qstat),
		.push         (push),
		.push_word    (push_word)
	);

	// Decouple front and back so either side may stall alone.
	scm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.pop_word  (pop_word),
		.qstat     (qstat)
	);

	// Back end: accumulate, then scale, saturate and hold the frame word.
	scm_back #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.qstat       (qstat),
		.pop_word    (pop_word),
		.pop         (pop),
		.finishing   (finishing),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame_word  (frame_word)
	);

	// Never pop an empty queue, never push a full one.
	`SCM_ASSERT_NOW(a_pop_not_empty, pop, !qstat.empty, "pop from empty queue")
	`SCM_ASSERT_NOW(a_push_not_full, push, !qstat.full, "push into full queue")
	// A new frame word only follows the saturate step.
	`SCM_ASSERT_NOW(a_frame_from_finish, $rose(frame_valid), $past(finishing),
		"frame word without finish step")
	// Popping a last word always starts the finish sequence.
	`SCM_ASSERT_NEXT(a_last_starts_finish, pop && pop_word.last_channel, !pop,
		"back end kept popping after last word")

endmodule

`default_nettype wire

// ----- bench/tb_stereo_channel_mixer_core.sv -----
// Self-checking testbench for the stereo channel mixer core: directed and random frames.
module tb_stereo_channel_mixer_core;
	import scm_pkg::*;

	localparam int ACC_W     = ACC_WIDTH_DEF;
	// Cycles to let in-flight words settle once no frame is outstanding
	localparam int SETTLE    = 16;
	localparam int SHOW_MAX  = 10;

	typedef enum logic {RX_ALWAYS, RX_PATTERN} rx_mode_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                sample_valid = 1'b0;
	logic                sample_ready;
	in_word_t            sample_word = '0;
	logic                frame_valid;
	logic                frame_ready = 1'b0;
	out_word_t           frame_word;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	stereo_channel_mixer_core #(.ACC_WIDTH(ACC_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample_word(sample_word),
		.frame_valid(frame_valid),
		.frame_ready(frame_ready),
		.frame_word(frame_word),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 0;
	end

	// Shadow copy of the mixer: register settings and the two frame accumulators
	logic [9:0]        cfg_master_vol = MASTER_VOLUME_RST;
	logic              cfg_out8       = OUTPUT_8BIT_RST;
	logic              cfg_stereo     = OUTPUT_STEREO_RST;
	logic [ACC_W-1:0]  left_acc  = '0;
	logic [ACC_W-1:0]  right_acc = '0;

	// Frames still owed by the block, oldest first
	out_word_t         frame_expect_q[$];

	int fault_count   = 0;
	int items_sent    = 0;
	int frames_seen   = 0;
	int reg_writes    = 0;

	// Sender pacing state
	bit offering   = 1'b0;
	bit tx_smooth  = 1'b0;
	int burst_left = 0;

	// Receiver pattern and long hold-off request
	rx_mode_t rx_mode     = RX_ALWAYS;
	int       rx_hold_len = 0;
	bit       rx_hold_go  = 1'b0;

	// One channel's share of one side of the frame, before wrap to the accumulator width
	function automatic longint side_contribution(logic signed [15:0] s, logic is8,
			logic [9:0] vol);
		longint gain;
		if (is8) begin
			// Clamp the gain to 255, then keep five bits of it
			gain = (vol > 10'd255) ? 255 : vol;
			return longint'($signed(s[7:0])) * (gain >>> 3) * 8;
		end
		return (longint'(s) * longint'(vol)) >>> 8;
	endfunction

	// Master gain, floor shift, saturate, then the optional 8-bit offset form
	function automatic logic [15:0] scale_side(logic [ACC_W-1:0] acc);
		longint a;
		longint v;
		a = longint'($signed(acc));
		v = (a * longint'(cfg_master_vol)) >>> 8;
		if (v > 32767)
			v = 32767;
		else if (v < -32768)
			v = -32768;
		if (cfg_out8)
			v = (v >>> 8) + 128;
		return v[15:0];
	endfunction

	// Fold one accepted word into the shadow accumulators; queue a frame when it closes one
	task automatic mix_item(in_word_t w);
		out_word_t f;
		left_acc  = left_acc  + ACC_W'(side_contribution(w.sample_value, w.sample_is_8bit,
			w.left_volume));
		right_acc = right_acc + ACC_W'(side_contribution(w.sample_value, w.sample_is_8bit,
			w.right_volume));
		if (w.last_channel) begin
			f.left_sample  = scale_side(left_acc);
			f.right_sample = cfg_stereo ? scale_side(right_acc) : 16'sd0;
			frame_expect_q.push_back(f);
			left_acc  = '0;
			right_acc = '0;
		end
	endtask

	task automatic report_mismatch(string what, logic [15:0] exp_v, logic [15:0] act_v);
		fault_count++;
		if (fault_count <= SHOW_MAX)
			$display("MISMATCH %s: expected %0d (%h) got %0d (%h)", what,
				int'($signed(exp_v)), exp_v, int'($signed(act_v)), act_v);
	endtask

	// Receiver: check every accepted frame word, then pick the next ready level.
	// Sampling right after the edge sees the values the block saw at that edge.
	int rx_hold_cnt = 0;
	bit rx_hold_seen = 1'b0;
	bit rx_on = 1'b1;
	int rx_run = 0;
	always @(posedge clk) begin
		out_word_t f;
		if (arst_n && frame_valid && frame_ready) begin
			frames_seen++;
			if (frame_expect_q.size() == 0) begin
				fault_count++;
				if (fault_count <= SHOW_MAX)
					$display("MISMATCH unexpected frame word L=%h R=%h",
						frame_word.left_sample, frame_word.right_sample);
			end else begin
				f = frame_expect_q.pop_front();
				if (frame_word.left_sample !== f.left_sample)
					report_mismatch("left_sample", f.left_sample, frame_word.left_sample);
				if (frame_word.right_sample !== f.right_sample)
					report_mismatch("right_sample", f.right_sample, frame_word.right_sample);
			end
		end
		// Load a long hold-off when one is requested, and count it down here
		if (rx_hold_go != rx_hold_seen) begin
			rx_hold_seen = rx_hold_go;
			rx_hold_cnt  = rx_hold_len;
		end
		if (rx_hold_cnt > 0) begin
			rx_hold_cnt--;
			frame_ready <= 1'b0;
		end else if (rx_mode == RX_ALWAYS) begin
			frame_ready <= 1'b1;
		end else begin
			// Alternate ready runs and stall runs of random length
			if (rx_run == 0) begin
				rx_on  = !rx_on;
				rx_run = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 6);
			end
			rx_run--;
			frame_ready <= rx_on;
		end
	end

	// Drop valid unless it is already dropped in this step
	task automatic sender_stop();
		if (offering) begin
			sample_valid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	// Count down the current burst; at its end insert a random gap
	task automatic sender_pace();
		int gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = tx_smooth ? 0 : $urandom_range(0, 7);
			if (gap > 0) begin
				sender_stop();
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Offer one sample word and hold it until accepted; call only at a rising edge
	task automatic send_sample(in_word_t w);
		sample_valid <= 1'b1;
		sample_word  <= w;
		offering = 1'b1;
		do @(posedge clk); while (!sample_ready);
		mix_item(w);
		items_sent++;
		sender_pace();
	endtask

	// Pause the sender until every frame has come back, then let the pipe settle
	task automatic wait_drained();
		sender_stop();
		while (frame_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [PDATA_W-1:0] reg_mask(logic [1:0] idx);
		case (idx)
			REG_MASTER_VOLUME: return 32'h3ff;
			REG_OUTPUT_8BIT:   return 32'h1;
			REG_OUTPUT_STEREO: return 32'h1;
			default:           return 32'h0;
		endcase
	endfunction

	// Write a register while the block is idle; junk goes into the unused bits
	task automatic write_reg(logic [1:0] idx, logic [PDATA_W-1:0] val);
		logic [PDATA_W-1:0] m;
		m = reg_mask(idx);
		wait_drained();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= ($urandom() & ~m) | (val & m);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_MASTER_VOLUME: cfg_master_vol = val[9:0];
			REG_OUTPUT_8BIT:   cfg_out8       = val[0];
			REG_OUTPUT_STEREO: cfg_stereo     = val[0];
			default: ;
		endcase
		reg_writes++;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Read a register and compare the implemented bits with the shadow setting
	task automatic read_check(logic [1:0] idx, logic [PDATA_W-1:0] exp_v);
		logic [PDATA_W-1:0] m;
		m = reg_mask(idx);
		// Idle first so the previous transfer's release lands on its own edge
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if ((prdata & m) !== (exp_v & m))
			report_mismatch("register read", 16'(exp_v & m), 16'(prdata & m));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic in_word_t make_word(logic [15:0] s, logic is8, logic [9:0] lv,
			logic [9:0] rv, logic last);
		in_word_t w;
		w.sample_value   = s;
		w.sample_is_8bit = is8;
		w.left_volume    = lv;
		w.right_volume   = rv;
		w.last_channel   = last;
		return w;
	endfunction

	// Mostly random gains, with the clamp and shift edges mixed in
	function automatic logic [9:0] pick_volume();
		logic [9:0] edges[6] = '{10'd0, 10'd7, 10'd8, 10'd255, 10'd256, 10'd1023};
		if ($urandom_range(0, 9) < 3)
			return edges[$urandom_range(0, 5)];
		return 10'($urandom_range(0, 1023));
	endfunction

	function automatic in_word_t random_word(logic last);
		logic [15:0] s;
		logic [15:0] edges[4] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
		s = ($urandom_range(0, 9) == 0) ? edges[$urandom_range(0, 3)] : 16'($urandom());
		return make_word(s, 1'($urandom()), pick_volume(), pick_volume(), last);
	endfunction

	// Reset values, then every register at both ends, read back each time
	task automatic test_register_access();
		read_check(REG_MASTER_VOLUME, MASTER_VOLUME_RST);
		read_check(REG_OUTPUT_8BIT, OUTPUT_8BIT_RST);
		read_check(REG_OUTPUT_STEREO, OUTPUT_STEREO_RST);
		write_reg(REG_MASTER_VOLUME, 32'd1023);
		read_check(REG_MASTER_VOLUME, 32'd1023);
		write_reg(REG_MASTER_VOLUME, 32'd0);
		read_check(REG_MASTER_VOLUME, 32'd0);
		write_reg(REG_OUTPUT_8BIT, 32'd1);
		read_check(REG_OUTPUT_8BIT, 32'd1);
		write_reg(REG_OUTPUT_STEREO, 32'd0);
		read_check(REG_OUTPUT_STEREO, 32'd0);
		write_reg(REG_MASTER_VOLUME, MASTER_VOLUME_RST);
		write_reg(REG_OUTPUT_8BIT, OUTPUT_8BIT_RST);
		write_reg(REG_OUTPUT_STEREO, OUTPUT_STEREO_RST);
		read_check(REG_MASTER_VOLUME, MASTER_VOLUME_RST);
	endtask

	// Field extremes and each named corner, a few words at a time
	task automatic test_directed();
		tx_smooth = 1'b1;
		// Full-scale 16-bit sources saturate at unity master gain
		send_sample(make_word(16'h7fff, 1'b0, 10'd1023, 10'd1023, 1'b1));
		send_sample(make_word(16'h8000, 1'b0, 10'd1023, 10'd0, 1'b1));
		// 8-bit source: gain above 255 clamps, gain below 8 vanishes
		send_sample(make_word(16'h007f, 1'b1, 10'd1023, 10'd255, 1'b1));
		send_sample(make_word(16'hff80, 1'b1, 10'd256, 10'd7, 1'b1));
		// High byte is ignored for 8-bit sources; floor shift on a tiny negative
		send_sample(make_word(16'h5a81, 1'b1, 10'd8, 10'd1000, 1'b0));
		send_sample(make_word(16'hffff, 1'b0, 10'd1, 10'd1, 1'b1));
		// Both gains zero still honor the frame end
		send_sample(make_word(16'h1234, 1'b0, 10'd0, 10'd0, 1'b1));
		send_sample(make_word(16'h7fff, 1'b1, 10'd0, 10'd0, 1'b0));
		send_sample(make_word(16'h0100, 1'b0, 10'd300, 10'd600, 1'b0));
		send_sample(make_word(16'hc000, 1'b0, 10'd512, 10'd64, 1'b1));
		// Master gain at both ends
		write_reg(REG_MASTER_VOLUME, 32'd0);
		send_sample(make_word(16'h7fff, 1'b0, 10'd1023, 10'd1023, 1'b1));
		write_reg(REG_MASTER_VOLUME, 32'd1023);
		send_sample(make_word(16'h0040, 1'b0, 10'd256, 10'd255, 1'b1));
		send_sample(make_word(16'hfffe, 1'b0, 10'd128, 10'd1023, 1'b1));
		// 8-bit output form: saturated, small negative, zero
		write_reg(REG_OUTPUT_8BIT, 32'd1);
		send_sample(make_word(16'h7fff, 1'b0, 10'd1023, 10'd1023, 1'b1));
		send_sample(make_word(16'hffff, 1'b0, 10'd1, 10'd1023, 1'b1));
		send_sample(make_word(16'h0000, 1'b0, 10'd1023, 10'd1023, 1'b1));
		// Mono: right reads zero and its accumulator still clears
		write_reg(REG_OUTPUT_STEREO, 32'd0);
		write_reg(REG_MASTER_VOLUME, 32'd256);
		send_sample(make_word(16'h4000, 1'b0, 10'd200, 10'd1023, 1'b1));
		write_reg(REG_OUTPUT_8BIT, 32'd0);
		send_sample(make_word(16'h2000, 1'b0, 10'd900, 10'd1023, 1'b1));
		write_reg(REG_OUTPUT_STEREO, 32'd1);
		send_sample(make_word(16'h0000, 1'b0, 10'd0, 10'd0, 1'b1));
		tx_smooth = 1'b0;
		wait_drained();
	endtask

	// Random frames over several register settings and receiver patterns
	task automatic test_random_frames();
		int          sent;
		int          flen;
		logic [9:0]  mv;
		logic        o8;
		logic        st;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0:       mv = 10'd0;
				1:       mv = 10'd1023;
				2:       mv = 10'd256;
				3:       mv = 10'd1;
				default: mv = 10'($urandom_range(0, 1023));
			endcase
			o8 = (ph < 4) ? ph[0] : 1'($urandom());
			st = (ph < 4) ? ph[1] : 1'($urandom());
			write_reg(REG_MASTER_VOLUME, 32'(mv));
			write_reg(REG_OUTPUT_8BIT, 32'(o8));
			write_reg(REG_OUTPUT_STEREO, 32'(st));
			rx_mode <= (ph % 3 == 0) ? RX_ALWAYS : RX_PATTERN;
			tx_smooth = (ph == 5);
			sent = 0;
			while (sent < 220) begin
				// Mostly short frames, now and then a long one
				flen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) :
					$urandom_range(1, 6);
				for (int k = 0; k < flen; k++)
					send_sample(random_word((k == flen - 1) || ($urandom_range(0, 19) == 0)));
				sent += flen;
			end
		end
		tx_smooth = 1'b0;
		wait_drained();
	endtask

	// Hold the frame port off while words keep coming, so the queue fills
	task automatic test_back_pressure();
		rx_mode     <= RX_ALWAYS;
		rx_hold_len <= 300;
		rx_hold_go  <= ~rx_hold_go;
		tx_smooth = 1'b1;
		repeat (40) send_sample(random_word(1'b1));
		wait_drained();
		// Second round with stalls and gaps, frames of mixed length
		rx_mode     <= RX_PATTERN;
		rx_hold_len <= 150;
		rx_hold_go  <= ~rx_hold_go;
		tx_smooth = 1'b0;
		repeat (60) send_sample(random_word(($urandom_range(0, 2) == 0)));
		send_sample(random_word(1'b1));
		wait_drained();
	endtask

	// One long frame drives both accumulators far past the output range
	task automatic test_long_frame();
		write_reg(REG_MASTER_VOLUME, 32'd256);
		write_reg(REG_OUTPUT_8BIT, 32'd0);
		write_reg(REG_OUTPUT_STEREO, 32'd1);
		rx_mode <= RX_ALWAYS;
		tx_smooth = 1'b1;
		for (int k = 0; k < 120; k++)
			send_sample(make_word((k[0]) ? 16'h7fff : 16'h8000, 1'b0,
				k[0] ? 10'd1023 : 10'd0, k[0] ? 10'd0 : 10'd1023, 1'b0));
		send_sample(make_word(16'h7fff, 1'b0, 10'd1023, 10'd0, 1'b1));
		tx_smooth = 1'b0;
		wait_drained();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_access();
		test_directed();
		test_random_frames();
		test_back_pressure();
		test_long_frame();
		wait_drained();
		// Count anything the block never delivered
		fault_count += frame_expect_q.size();
		$display("Summary: %0d sample words, %0d frame words, %0d register writes",
			items_sent, frames_seen, reg_writes);
		$display("Covered 8/16-bit sources, gain clamp, master gain ends, mono/stereo, %s",
			"8/16-bit output, saturation, long frames and back-pressure");
		if (fault_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// Hard stop well past the slowest legal run
	initial begin
		#8000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/scm_pkg.sv
hw/rtl/scm_front.sv
hw/rtl/scm_queue.sv
hw/rtl/scm_back.sv
hw/rtl/stereo_channel_mixer_core.sv
bench/tb_stereo_channel_mixer_core.sv
